// File: hw/rtl/motion_vector_field_subdivider_assert.svh
// assertion macros for the vector field subdivider
`ifndef MOTION_VECTOR_FIELD_SUBDIVIDER_ASSERT_SVH
`define MOTION_VECTOR_FIELD_SUBDIVIDER_ASSERT_SVH

// checked outside reset
`define MVFS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mvfs check failed");

// checked on every edge, reset included
`define MVFS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mvfs reset check failed");

`endif

// File: hw/rtl/mvfs_pkg.sv
`timescale 1ns / 1ps

package mvfs_pkg;

  localparam int MAX_BLOCKS_ACROSS_DEF = 512;
  localparam int MAX_BLOCKS_DOWN_DEF   = 512;

  localparam int MV_W       = 16;
  localparam int COST_IN_W  = 31;
  localparam int COST_OUT_W = 29;
  localparam int COORD_W    = 10;
  localparam int CFG_DATA_W = 10;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t REG_DIVIDE_MODE   = 2'd0;
  localparam cfg_index_t REG_BLOCKS_ACROSS = 2'd1;
  localparam cfg_index_t REG_BLOCKS_DOWN   = 2'd2;

  typedef struct packed {
    logic signed [MV_W-1:0] vx;
    logic signed [MV_W-1:0] vy;
  } vec_t;

  typedef vec_t [3:0] quad_t;

  typedef struct packed {
    logic signed [MV_W-1:0] in_vx;
    logic signed [MV_W-1:0] in_vy;
    logic [COST_IN_W-1:0]   in_cost;
  } in_word_t;

  typedef struct packed {
    logic [COORD_W-1:0]     sub_col;
    logic [COORD_W-1:0]     sub_row;
    logic signed [MV_W-1:0] out_vx;
    logic signed [MV_W-1:0] out_vy;
    logic [COST_OUT_W-1:0]  out_cost;
    logic                   frame_end;
  } out_word_t;

  // one finished block: up to eight sub-block words
  typedef struct packed {
    quad_t                 quad;
    logic [COST_OUT_W-1:0] mid_cost;
    vec_t                  cur;
    logic [COST_OUT_W-1:0] cur_cost;
    logic [COORD_W-1:0]    col_base;
    logic [COORD_W-1:0]    top_row_base;
    logic [COORD_W-1:0]    last_row_base;
    logic                  has_mid;
    logic                  has_last;
    logic                  frame_last;
  } blk_t;

endpackage

// File: hw/rtl/mvfs_ram.sv
`timescale 1ns / 1ps

module mvfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic                                          rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]                              rd_data_a,
  output logic [WIDTH-1:0]                              rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// File: hw/rtl/mvfs_median.sv
`timescale 1ns / 1ps

module mvfs_median (
  input  logic            inner,
  input  mvfs_pkg::vec_t  cen,
  input  mvfs_pkg::vec_t  left,
  input  mvfs_pkg::vec_t  right,
  input  mvfs_pkg::vec_t  up,
  input  mvfs_pkg::vec_t  below,
  output mvfs_pkg::quad_t quad
);

  import mvfs_pkg::*;

  function automatic logic signed [MV_W-1:0] med3(input logic signed [MV_W-1:0] a,
                                                  input logic signed [MV_W-1:0] b,
                                                  input logic signed [MV_W-1:0] c);
    if ((b <= a && a <= c) || (c <= a && a <= b)) begin
      return a;
    end
    if ((a <= b && b <= c) || (c <= b && b <= a)) begin
      return b;
    end
    return c;
  endfunction

  function automatic vec_t pick(input vec_t c, input vec_t h, input vec_t v);
    vec_t m;
    m.vx = med3(c.vx, h.vx, v.vx);
    m.vy = med3(c.vy, h.vy, v.vy);
    if (m == c || m == h || m == v) begin
      return m;
    end
    return c;
  endfunction

  // order: top-left, top-right, bottom-left, bottom-right
  always_comb begin
    if (inner) begin
      quad[0] = pick(cen, left, up);
      quad[1] = pick(cen, right, up);
      quad[2] = pick(cen, left, below);
      quad[3] = pick(cen, right, below);
    end else begin
      quad[0] = cen;
      quad[1] = cen;
      quad[2] = cen;
      quad[3] = cen;
    end
  end

endmodule

// File: hw/rtl/mvfs_emit.sv
`timescale 1ns / 1ps

module mvfs_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                blk_valid,
  output logic                blk_ready,
  input  mvfs_pkg::blk_t      blk,
  output logic                out_valid,
  input  logic                out_ready,
  output mvfs_pkg::out_word_t out_data
);

  import mvfs_pkg::*;

  logic      hold_valid;
  blk_t      hold;
  logic [2:0] idx;
  logic [2:0] idx_final;
  logic      out_load;
  logic      emit_now;
  logic      done;
  logic      sel_cur;
  vec_t      sel_vec;
  out_word_t word;

  assign idx_final = {hold.has_last, 2'b11};
  assign out_load  = !out_valid || out_ready;
  assign emit_now  = hold_valid && out_load;
  assign done      = emit_now && (idx == idx_final);
  assign blk_ready = !hold_valid || done;

  // index bit 2 picks the current row, bit 1 the lower half, bit 0 the right half
  always_comb begin
    sel_cur = idx[2];
    sel_vec = sel_cur ? hold.cur : hold.quad[idx[1:0]];
    word.sub_col = {hold.col_base[COORD_W-1:1], idx[0]};
    word.sub_row = sel_cur ? {hold.last_row_base[COORD_W-1:1], idx[1]}
                           : {hold.top_row_base[COORD_W-1:1], idx[1]};
    word.out_vx    = sel_vec.vx;
    word.out_vy    = sel_vec.vy;
    word.out_cost  = sel_cur ? hold.cur_cost : hold.mid_cost;
    word.frame_end = sel_cur && (idx[1:0] == 2'b11) && hold.frame_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      idx        <= '0;
    end else begin
      if (blk_valid && blk_ready) begin
        hold_valid <= 1'b1;
        idx        <= {!blk.has_mid, 2'b00};
      end else if (done) begin
        hold_valid <= 1'b0;
      end else if (emit_now) begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (blk_valid && blk_ready) begin
      hold <= blk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      out_data <= word;
    end
  end

endmodule

// File: hw/rtl/motion_vector_field_subdivider.sv
`timescale 1ns / 1ps

// Splits a raster-order block vector field into 2x2 sub-blocks, one sub-block word per
// cycle while out_ready holds. Each accepted block word yields the four sub-blocks of
// the block directly above it (none on row 0), and on the last block row its own four
// as well. A new block word is taken while the previous one still drains. The first
// word of a block passes the read stage, the emit hold register and the output
// register. The two row stores are single-write, dual-read memories read on
// acceptance; they need no clearing pass, so the block accepts input from the first
// cycle after reset. Configuration (divide_mode, blocks_across, blocks_down) is
// written on a separate channel; the user must write it only while idle (not enforced).
module motion_vector_field_subdivider #(
  parameter int MAX_BLOCKS_ACROSS = mvfs_pkg::MAX_BLOCKS_ACROSS_DEF,
  parameter int MAX_BLOCKS_DOWN   = mvfs_pkg::MAX_BLOCKS_DOWN_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  mvfs_pkg::cfg_index_t              cfg_index,
  input  logic [mvfs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mvfs_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mvfs_pkg::out_word_t               out_data
);

  import mvfs_pkg::*;

  localparam int COL_W = (MAX_BLOCKS_ACROSS > 1) ? $clog2(MAX_BLOCKS_ACROSS) : 1;
  localparam int ROW_W = $clog2(MAX_BLOCKS_DOWN);
  localparam int AW    = $clog2(MAX_BLOCKS_ACROSS + 1);
  localparam int DW    = $clog2(MAX_BLOCKS_DOWN + 1);

  logic                  divide_mode;
  logic [CFG_DATA_W-1:0] blocks_across;
  logic [CFG_DATA_W-1:0] blocks_down;

  logic [COL_W-1:0] column_count;
  logic [COL_W-1:0] column_count_next;
  logic [ROW_W-1:0] row_count;
  logic [ROW_W-1:0] row_count_next;

  logic [AW-1:0]    across_eff;
  logic [DW-1:0]    down_eff;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [ROW_W:0]   row_step;
  logic [COL_W:0]   col_inc;
  logic             col_wrap;
  logic             is_last;
  logic             is_inner;
  logic             in_fire;

  logic             s1_valid;
  in_word_t         s1_cur;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic             s1_last;
  logic             s1_mid;
  logic             s1_inner;
  logic             s1_end;
  logic             s1_go;
  logic             s1_has;

  in_word_t   mid_a;
  in_word_t   mid_b;
  logic [31:0] up_rd;
  vec_t       cen;
  vec_t       right;
  vec_t       up;
  vec_t       below;
  vec_t       left;
  quad_t      quad;

  blk_t blk;
  logic blk_valid;
  logic blk_ready;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      divide_mode   <= 1'b0;
      blocks_across <= CFG_DATA_W'(1);
      blocks_down   <= CFG_DATA_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DIVIDE_MODE:   divide_mode   <= cfg_data[0];
        REG_BLOCKS_ACROSS: blocks_across <= cfg_data;
        REG_BLOCKS_DOWN:   blocks_down   <= cfg_data;
        default: ;
      endcase
    end
  end

  // field position of the incoming word
  always_comb begin
    if (blocks_across == '0) begin
      across_eff = AW'(1);
    end else if (32'(blocks_across) > 32'(MAX_BLOCKS_ACROSS)) begin
      across_eff = AW'(MAX_BLOCKS_ACROSS);
    end else begin
      across_eff = AW'(blocks_across);
    end

    if (32'(blocks_down) < 32'd2) begin
      down_eff = DW'(2);
    end else if (32'(blocks_down) > 32'(MAX_BLOCKS_DOWN)) begin
      down_eff = DW'(MAX_BLOCKS_DOWN);
    end else begin
      down_eff = DW'(blocks_down);
    end

    cur_col  = column_count;
    row_step = {1'b0, row_count};
    if (32'(column_count) >= 32'(across_eff)) begin
      cur_col  = '0;
      row_step = row_step + (ROW_W + 1)'(1);
    end
    if (32'(row_step) >= 32'(down_eff)) begin
      cur_row = '0;
    end else begin
      cur_row = ROW_W'(row_step);
    end

    is_last  = (32'(cur_row) == (32'(down_eff) - 32'd1));
    col_inc  = {1'b0, cur_col} + (COL_W + 1)'(1);
    col_wrap = (32'(col_inc) >= 32'(across_eff));
    is_inner = divide_mode && (32'(cur_row) >= 32'd2) && (cur_col != '0) && !col_wrap;

    column_count_next = col_wrap ? '0 : COL_W'(col_inc);
    if (col_wrap) begin
      row_count_next = is_last ? '0 : cur_row + ROW_W'(1);
    end else begin
      row_count_next = cur_row;
    end
  end

  assign in_fire  = in_valid && in_ready;
  assign s1_has   = s1_mid || s1_last;
  assign s1_go    = s1_valid && (!s1_has || blk_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_fire) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // row stores: middle row records and upper row vectors
  mvfs_ram #(
    .WIDTH ($bits(in_word_t)),
    .DEPTH (MAX_BLOCKS_ACROSS)
  ) u_mid_ram (
    .clk       (clk),
    .wr_en     (in_fire),
    .wr_addr   (cur_col),
    .wr_data   (in_data),
    .rd_en     (in_fire),
    .rd_addr_a (cur_col),
    .rd_addr_b (COL_W'(col_inc)),
    .rd_data_a (mid_a),
    .rd_data_b (mid_b)
  );

  mvfs_ram #(
    .WIDTH ($bits(vec_t)),
    .DEPTH (MAX_BLOCKS_ACROSS)
  ) u_up_ram (
    .clk       (clk),
    .wr_en     (s1_valid && s1_mid),
    .wr_addr   (s1_col),
    .wr_data   (cen),
    .rd_en     (in_fire),
    .rd_addr_a (cur_col),
    .rd_addr_b (cur_col),
    .rd_data_a (up_rd),
    .rd_data_b ()
  );

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cur   <= in_data;
      s1_col   <= cur_col;
      s1_row   <= cur_row;
      s1_last  <= is_last;
      s1_mid   <= (cur_row != '0);
      s1_inner <= is_inner;
      s1_end   <= is_last && col_wrap;
    end
  end

  // left neighbor is the previous block's center
  always_ff @(posedge clk) begin
    if (s1_go && s1_mid) begin
      left <= cen;
    end
  end

  always_comb begin
    cen.vx   = mid_a.in_vx;
    cen.vy   = mid_a.in_vy;
    right.vx = mid_b.in_vx;
    right.vy = mid_b.in_vy;
    up       = vec_t'(up_rd);
    below.vx = s1_cur.in_vx;
    below.vy = s1_cur.in_vy;
  end

  mvfs_median u_median (
    .inner (s1_inner),
    .cen   (cen),
    .left  (left),
    .right (right),
    .up    (up),
    .below (below),
    .quad  (quad)
  );

  always_comb begin
    blk.quad          = quad;
    blk.mid_cost      = mid_a.in_cost[COST_IN_W-1:2];
    blk.cur           = below;
    blk.cur_cost      = s1_cur.in_cost[COST_IN_W-1:2];
    blk.col_base      = COORD_W'({s1_col, 1'b0});
    blk.top_row_base  = COORD_W'({ROW_W'(s1_row - ROW_W'(1)), 1'b0});
    blk.last_row_base = COORD_W'({s1_row, 1'b0});
    blk.has_mid       = s1_mid;
    blk.has_last      = s1_last;
    blk.frame_last    = s1_end;
  end

  assign blk_valid = s1_valid && s1_has;

  mvfs_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk       (blk),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/mvfs_checker.sv
`timescale 1ns / 1ps

`include "motion_vector_field_subdivider_assert.svh"

module mvfs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input mvfs_pkg::cfg_index_t            cfg_index,
  input logic [mvfs_pkg::CFG_DATA_W-1:0] cfg_data,
  input logic                            in_valid,
  input logic                            in_ready,
  input mvfs_pkg::in_word_t              in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input mvfs_pkg::out_word_t             out_data
);

  import mvfs_pkg::*;

  logic [$bits(cfg_index_t)+CFG_DATA_W-1:0] cfg_word;
  logic                                     bottom_right;

  assign cfg_word     = {cfg_index, cfg_data};
  assign bottom_right = out_data.sub_col[0] && out_data.sub_row[0];

  // a stalled word holds
  `MVFS_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // an offered block word holds until taken
  `MVFS_ASSERT(a_in_hold, clk, rst, in_valid && !in_ready |=> in_valid && $stable(in_data))

  // a pending register write holds
  `MVFS_ASSERT(a_cfg_hold, clk, rst, cfg_valid && !cfg_ready |=> cfg_valid && $stable(cfg_word))

  // the frame closes on a bottom-right sub-block
  `MVFS_ASSERT(a_end_corner, clk, rst, out_valid && out_data.frame_end |-> bottom_right)

  // reset leaves an empty pipeline that takes input and configuration
  `MVFS_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid && in_ready && cfg_ready)

endmodule

bind motion_vector_field_subdivider mvfs_checker u_checker (.*);

// File: tb/motion_vector_field_subdivider_test.sv
`timescale 1ns / 1ps

module motion_vector_field_subdivider_test;
  import mvfs_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_BLOCKS = 220;
  localparam int LONG_HOLD = 400;
  localparam cfg_index_t REG_UNUSED = 2'd3;

  typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_MOSTLY} ready_style_t;

  class subdivider_scoreboard;
    vec_t                  upper_vecs [MAX_BLOCKS_ACROSS_DEF];
    in_word_t              middle_blocks [MAX_BLOCKS_ACROSS_DEF];
    int unsigned           col_pos;
    int unsigned           row_pos;
    logic                  median_on;
    logic [CFG_DATA_W-1:0] across_reg;
    logic [CFG_DATA_W-1:0] down_reg;
    out_word_t             sub_words [$];
    int unsigned           mismatches;
    int unsigned           blocks_noted;
    int unsigned           words_checked;
    int unsigned           median_blocks;
    int unsigned           reg_writes;

    function new();
      col_pos = 0;
      row_pos = 0;
      median_on = 1'b0;
      across_reg = 1;
      down_reg = 2;
      mismatches = 0;
      blocks_noted = 0;
      words_checked = 0;
      median_blocks = 0;
      reg_writes = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_DIVIDE_MODE: begin
          median_on = data[0];
        end
        REG_BLOCKS_ACROSS: begin
          across_reg = data;
        end
        REG_BLOCKS_DOWN: begin
          down_reg = data;
        end
        default: begin
        end
      endcase
    endfunction

    function int unsigned eff_across();
      int unsigned a;
      a = across_reg;
      if (a < 1) a = 1;
      if (a > MAX_BLOCKS_ACROSS_DEF) a = MAX_BLOCKS_ACROSS_DEF;
      return a;
    endfunction

    function int unsigned eff_down();
      int unsigned d;
      d = down_reg;
      if (d < 2) d = 2;
      if (d > MAX_BLOCKS_DOWN_DEF) d = MAX_BLOCKS_DOWN_DEF;
      return d;
    endfunction

    function int unsigned field_blocks();
      return eff_across() * eff_down();
    endfunction

    function logic signed [MV_W-1:0] mid_of3(logic signed [MV_W-1:0] a, b, c);
      logic signed [MV_W-1:0] lo;
      logic signed [MV_W-1:0] hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (c <= lo) return lo;
      if (c >= hi) return hi;
      return c;
    endfunction

    // median pair only if it matches one of the three vectors
    function vec_t pick_median(vec_t cen, vec_t side, vec_t vert);
      vec_t m;
      m.vx = mid_of3(cen.vx, side.vx, vert.vx);
      m.vy = mid_of3(cen.vy, side.vy, vert.vy);
      if (m == cen || m == side || m == vert) return m;
      return cen;
    endfunction

    function void queue_word(int unsigned col, int unsigned row, vec_t v,
                             logic [COST_OUT_W-1:0] cost, logic last_word);
      out_word_t wd;
      wd.sub_col = COORD_W'(col);
      wd.sub_row = COORD_W'(row);
      wd.out_vx = v.vx;
      wd.out_vy = v.vy;
      wd.out_cost = cost;
      wd.frame_end = last_word;
      sub_words.push_back(wd);
    endfunction

    function void note_block(in_word_t w);
      int unsigned           across;
      int unsigned           down;
      int unsigned           c;
      int unsigned           r;
      logic                  last_row;
      vec_t                  cur;
      vec_t                  cen;
      vec_t                  left;
      vec_t                  right;
      vec_t                  up;
      vec_t                  quad [4];
      logic [COST_OUT_W-1:0] cost;
      across = eff_across();
      down = eff_down();
      c = col_pos;
      r = row_pos;
      blocks_noted++;
      if (c >= across) begin
        c = 0;
        r++;
      end
      if (r >= down) r = 0;
      last_row = (r == down - 1);
      cur.vx = w.in_vx;
      cur.vy = w.in_vy;
      // the block above the current one is finished now
      if (r >= 1) begin
        cen.vx = middle_blocks[c].in_vx;
        cen.vy = middle_blocks[c].in_vy;
        cost = COST_OUT_W'(middle_blocks[c].in_cost >> 2);
        for (int k = 0; k < 4; k++) quad[k] = cen;
        if (median_on == 1'b1 && r >= 2 && c >= 1 && c + 1 < across) begin
          left = upper_vecs[c - 1];
          up = upper_vecs[c];
          right.vx = middle_blocks[c + 1].in_vx;
          right.vy = middle_blocks[c + 1].in_vy;
          quad[0] = pick_median(cen, left, up);
          quad[1] = pick_median(cen, right, up);
          quad[2] = pick_median(cen, left, cur);
          quad[3] = pick_median(cen, right, cur);
          median_blocks++;
        end
        for (int k = 0; k < 4; k++)
          queue_word(2 * c + k % 2, 2 * (r - 1) + k / 2, quad[k], cost, 1'b0);
        upper_vecs[c] = cen;
      end
      middle_blocks[c] = w;
      if (last_row) begin
        for (int k = 0; k < 4; k++)
          queue_word(2 * c + k % 2, 2 * r + k / 2, cur, COST_OUT_W'(w.in_cost >> 2),
                     (k == 3) && (c == across - 1));
      end
      c++;
      if (c >= across) begin
        c = 0;
        r = last_row ? 0 : r + 1;
      end
      col_pos = c;
      row_pos = r;
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (sub_words.size() == 0) begin
        $error("sub-block word with none expected: col %0d row %0d",
               got.sub_col, got.sub_row);
        mismatches++;
        return;
      end
      want = sub_words.pop_front();
      words_checked++;
      if (got.sub_col !== want.sub_col) begin
        $error("sub_col: expected %0d, got %0d", want.sub_col, got.sub_col);
        mismatches++;
      end
      if (got.sub_row !== want.sub_row) begin
        $error("sub_row: expected %0d, got %0d", want.sub_row, got.sub_row);
        mismatches++;
      end
      if (got.out_vx !== want.out_vx) begin
        $error("out_vx: expected %0d, got %0d", want.out_vx, got.out_vx);
        mismatches++;
      end
      if (got.out_vy !== want.out_vy) begin
        $error("out_vy: expected %0d, got %0d", want.out_vy, got.out_vy);
        mismatches++;
      end
      if (got.out_cost !== want.out_cost) begin
        $error("out_cost: expected %0d, got %0d", want.out_cost, got.out_cost);
        mismatches++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return sub_words.size();
    endfunction

    function void close_out();
      if (sub_words.size() != 0) begin
        $error("%0d sub-block words never arrived", sub_words.size());
        mismatches += sub_words.size();
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_index_t            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_data;

  logic                  stall_req;
  logic                  stall_done;
  int                    burst_left;
  logic signed [MV_W-1:0] corner_vals [4] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};

  subdivider_scoreboard sb = new();

  motion_vector_field_subdivider uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_block(in_data);
      if (out_valid && out_ready) sb.check_word(out_data);
    end
  end

  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("no word moved for %0d cycles", IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // receiver: changing ready patterns, one long hold on request
  initial begin
    ready_style_t style;
    int           style_left;
    out_ready = 1'b0;
    stall_done = 1'b0;
    style = READY_ALWAYS;
    style_left = 0;
    forever begin
      @(negedge clk);
      if (stall_req && !stall_done) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        stall_done = 1'b1;
      end
      if (style_left == 0) begin
        style = ready_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(10, 80);
      end
      style_left--;
      case (style)
        READY_ALWAYS: out_ready = 1'b1;
        READY_HALF:   out_ready = $urandom_range(0, 1);
        READY_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
        default:      out_ready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic in_word_t make_block(int vx, int vy, int cost);
    in_word_t w;
    w.in_vx = MV_W'(vx);
    w.in_vy = MV_W'(vy);
    w.in_cost = COST_IN_W'(cost);
    return w;
  endfunction

  function automatic in_word_t random_block();
    in_word_t w;
    int       sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      w.in_vx = MV_W'($urandom_range(0, 6) - 3);
      w.in_vy = MV_W'($urandom_range(0, 6) - 3);
    end else if (sel < 9) begin
      w.in_vx = MV_W'($urandom());
      w.in_vy = MV_W'($urandom());
    end else begin
      w.in_vx = corner_vals[$urandom_range(0, 3)];
      w.in_vy = corner_vals[$urandom_range(0, 3)];
    end
    sel = $urandom_range(0, 9);
    if (sel == 0) w.in_cost = '0;
    else if (sel == 1) w.in_cost = '1;
    else w.in_cost = COST_IN_W'($urandom());
    return w;
  endfunction

  // sender works in bursts; valid stays up across a burst
  task automatic offer_block(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_data = w;
    in_valid = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid = 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic program_reg(input cfg_index_t idx, input int data);
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(data);
    cfg_valid = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    int random_blocks;
    int field_no;
    int pick;
    int mode;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_DIVIDE_MODE;
    cfg_data = '0;
    stall_req = 1'b0;
    burst_left = 0;
    random_blocks = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: one column, two rows, copy mode
    offer_block(make_block(32767, -32768, 32'h7fffffff));
    offer_block(make_block(-32768, 32767, 0));
    wait_for_drain();

    // 3x3 median field, center block exercises the fallback to the center vector
    program_reg(REG_DIVIDE_MODE, 10'h3ff);
    program_reg(REG_BLOCKS_ACROSS, 3);
    program_reg(REG_BLOCKS_DOWN, 3);
    program_reg(REG_UNUSED, 10'h2aa);
    offer_block(make_block(-32768, -32768, 1));
    offer_block(make_block(2, 1, 32'h7fffffff));
    offer_block(make_block(32767, 32767, 5));
    offer_block(make_block(1, 5, 12));
    offer_block(make_block(0, 0, 33));
    offer_block(make_block(-3, -3, 2));
    offer_block(make_block(-1, -1, 3));
    offer_block(make_block(5, 5, 7));
    offer_block(make_block(0, -32768, 100));
    wait_for_drain();

    // width shrinks mid-field: column wraps onto the last row
    repeat (4) offer_block(random_block());
    wait_for_drain();
    program_reg(REG_BLOCKS_ACROSS, 0);
    offer_block(random_block());
    wait_for_drain();

    // oversized sizes, then a narrower width mid-row
    program_reg(REG_BLOCKS_ACROSS, 1023);
    program_reg(REG_BLOCKS_DOWN, 1023);
    repeat (3) offer_block(random_block());
    wait_for_drain();
    program_reg(REG_BLOCKS_ACROSS, 2);
    program_reg(REG_BLOCKS_DOWN, 1);
    repeat (2) offer_block(random_block());
    wait_for_drain();

    // height shrinks mid-field: row wraps to the top
    program_reg(REG_BLOCKS_ACROSS, 1);
    program_reg(REG_BLOCKS_DOWN, 3);
    repeat (2) offer_block(random_block());
    wait_for_drain();
    program_reg(REG_BLOCKS_DOWN, 0);
    repeat (2) offer_block(random_block());
    wait_for_drain();

    field_no = 0;
    while (random_blocks < RANDOM_BLOCKS) begin
      mode = $urandom_range(0, 1);
      program_reg(REG_DIVIDE_MODE, ($urandom_range(0, 511) << 1) | mode);
      if (field_no == 3) begin
        program_reg(REG_DIVIDE_MODE, 1);
        program_reg(REG_BLOCKS_ACROSS, 8);
        program_reg(REG_BLOCKS_DOWN, 4);
        stall_req = 1'b1;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) program_reg(REG_BLOCKS_ACROSS, 0);
        else if (pick < 15) program_reg(REG_BLOCKS_ACROSS, $urandom_range(1, 6));
        else program_reg(REG_BLOCKS_ACROSS, $urandom_range(7, 16));
        pick = $urandom_range(0, 9);
        if (pick == 0) program_reg(REG_BLOCKS_DOWN, $urandom_range(0, 1));
        else program_reg(REG_BLOCKS_DOWN, $urandom_range(2, 5));
      end
      if ($urandom_range(0, 3) == 0) program_reg(REG_UNUSED, $urandom_range(0, 1023));
      random_blocks += sb.field_blocks();
      repeat (sb.field_blocks()) offer_block(random_block());
      wait_for_drain();
      field_no++;
    end

    repeat (30) @(negedge clk);
    sb.close_out();
    $display("covered %0d blocks over %0d random fields and %0d register writes",
             sb.blocks_noted, field_no, sb.reg_writes);
    $display("checked %0d sub-block words, %0d blocks took the median path",
             sb.words_checked, sb.median_blocks);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/mvfs_pkg.sv
hw/rtl/mvfs_ram.sv
hw/rtl/mvfs_median.sv
hw/rtl/mvfs_emit.sv
hw/rtl/motion_vector_field_subdivider.sv
hw/rtl/mvfs_checker.sv
tb/motion_vector_field_subdivider_test.sv
